// ===== hw/rtl/rmml_pkg.sv =====
// ----------------------------------------------------------------------------
// rmml_pkg
// shared types and constants of the ranked min/max list
// ----------------------------------------------------------------------------
package rmml_pkg;

   localparam int DEPTH       = 16;
   localparam int HANDLE_BITS = 16;
   localparam int IDX_BITS    = $clog2(DEPTH);
   localparam int CNT_BITS    = $clog2(DEPTH + 1);
   // stored handle bits: the handle field itself is 16 bits wide
   localparam int HSTORE_BITS = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

   typedef enum logic [0:0] {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic [0:0]  mode;
      logic [15:0] handle;
      logic [23:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] min_handle;
      logic [15:0] max_handle;
      logic [4:0]  entry_count;
      logic        is_empty;
   } rsp_type;

endpackage

// ===== hw/rtl/ranked_min_max_list.sv =====
// ----------------------------------------------------------------------------
// ranked_min_max_list
// sorted store of handle/key entries with front and back handle report
// ----------------------------------------------------------------------------
// One item is taken when start is high and busy is low. Busy then stays high
// until the single result is shown on rsp_item for exactly one cycle with
// rsp_valid high, and busy is already low in that cycle. The receiver cannot
// stall, so the result must be captured in that cycle. The entries live in a
// single-port-write, single-port-read memory with registered read data. One
// sequencer walks it one entry at a time, a read state before each check or
// move. An insert moves entries back from the tail until it meets a smaller
// key. A remove scans from the front for the handle and then shifts the tail
// forward. An insert into a full store or a remove from an empty one goes
// straight to reading the front and back entries. Among equal keys the
// newest entry sits at the front. A full store on insert and an absent handle
// on remove leave the store unchanged.
// ----------------------------------------------------------------------------
module ranked_min_max_list (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rmml_pkg::req_type req_item,
   output logic              rsp_valid,
   output rmml_pkg::rsp_type rsp_item
);

   // sequencer states
   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_INS_RD  = 10'b00_0000_0010,  // issue read of the entry before idx
      ST_INS_CHK = 10'b00_0000_0100,  // compare keys, move entry back or place
      ST_REM_RD  = 10'b00_0000_1000,  // issue read at idx during the search
      ST_REM_CHK = 10'b00_0001_0000,  // compare handle
      ST_SH_RD   = 10'b00_0010_0000,  // issue read of the entry after idx
      ST_SH_WR   = 10'b00_0100_0000,  // move it forward to idx
      ST_FR_RD   = 10'b00_1000_0000,  // read front entry
      ST_BK_RD   = 10'b01_0000_0000,  // read back entry, keep front
      ST_FINISH  = 10'b10_0000_0000   // build the result
   } state_type;

   state_type state_ff, state_in;

   // entry memory
   logic [23:0]                        key_mem [rmml_pkg::DEPTH];
   logic [rmml_pkg::HSTORE_BITS-1:0]   hdl_mem [rmml_pkg::DEPTH];
   logic [23:0]                        rd_key_ff;
   logic [rmml_pkg::HSTORE_BITS-1:0]   rd_hdl_ff;
   logic [rmml_pkg::IDX_BITS-1:0]      rd_addr;
   logic                               wr_en;
   logic [rmml_pkg::IDX_BITS-1:0]      wr_addr;
   logic [23:0]                        wr_key;
   logic [rmml_pkg::HSTORE_BITS-1:0]   wr_hdl;

   // control and operand registers
   logic [rmml_pkg::CNT_BITS-1:0]      count_ff, count_in;
   logic [rmml_pkg::IDX_BITS-1:0]      idx_ff, idx_in;
   logic [rmml_pkg::CNT_BITS-1:0]      idx_next;   // idx + 1, count-wide
   rmml_pkg::status_type               status_ff, status_in;
   logic [rmml_pkg::HSTORE_BITS-1:0]   op_hdl_ff, op_hdl_in;
   logic [23:0]                        op_key_ff, op_key_in;
   logic [rmml_pkg::HSTORE_BITS-1:0]   front_ff, front_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   rmml_pkg::rsp_type                  rsp_ff, rsp_in;

   assign idx_next = rmml_pkg::CNT_BITS'(idx_ff) + rmml_pkg::CNT_BITS'(1);

   // memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         hdl_mem[wr_addr] <= wr_hdl;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_hdl_ff <= hdl_mem[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      op_hdl_in    = op_hdl_ff;
      op_key_in    = op_key_ff;
      front_in     = front_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_key       = op_key_ff;
      wr_hdl       = op_hdl_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_hdl_in  = req_item.handle[rmml_pkg::HSTORE_BITS-1:0];
               op_key_in  = req_item.key;
               if (req_item.mode == rmml_pkg::MODE_INSERT) begin
                  if (count_ff == rmml_pkg::CNT_BITS'(rmml_pkg::DEPTH)) begin
                     status_in = rmml_pkg::STATUS_FULL;
                     state_in  = ST_FR_RD;
                  end else begin
                     // count is below DEPTH here, so it fits the index
                     idx_in   = count_ff[rmml_pkg::IDX_BITS-1:0];
                     state_in = ST_INS_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = rmml_pkg::STATUS_NOT_FOUND;
                     state_in  = ST_FR_RD;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_REM_RD;
                  end
               end
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               // new entry goes to the front
               wr_en     = 1'b1;
               count_in  = count_ff + rmml_pkg::CNT_BITS'(1);
               status_in = rmml_pkg::STATUS_DONE;
               state_in  = ST_FR_RD;
            end else begin
               rd_addr  = idx_ff - rmml_pkg::IDX_BITS'(1);
               state_in = ST_INS_CHK;
            end
         end
         ST_INS_CHK: begin
            wr_en = 1'b1;
            if (rd_key_ff >= op_key_ff) begin
               // equal or greater key moves back, newest ties stay in front
               wr_key   = rd_key_ff;
               wr_hdl   = rd_hdl_ff;
               idx_in   = idx_ff - rmml_pkg::IDX_BITS'(1);
               state_in = ST_INS_RD;
            end else begin
               count_in  = count_ff + rmml_pkg::CNT_BITS'(1);
               status_in = rmml_pkg::STATUS_DONE;
               state_in  = ST_FR_RD;
            end
         end
         ST_REM_RD: begin
            state_in = ST_REM_CHK;
         end
         ST_REM_CHK: begin
            if (rd_hdl_ff == op_hdl_ff) begin
               state_in = ST_SH_RD;
            end else if (idx_next == count_ff) begin
               status_in = rmml_pkg::STATUS_NOT_FOUND;
               state_in  = ST_FR_RD;
            end else begin
               idx_in   = idx_ff + rmml_pkg::IDX_BITS'(1);
               state_in = ST_REM_RD;
            end
         end
         ST_SH_RD: begin
            if (idx_next == count_ff) begin
               count_in  = count_ff - rmml_pkg::CNT_BITS'(1);
               status_in = rmml_pkg::STATUS_DONE;
               state_in  = ST_FR_RD;
            end else begin
               rd_addr  = idx_next[rmml_pkg::IDX_BITS-1:0];
               state_in = ST_SH_WR;
            end
         end
         ST_SH_WR: begin
            wr_en    = 1'b1;
            wr_key   = rd_key_ff;
            wr_hdl   = rd_hdl_ff;
            idx_in   = idx_ff + rmml_pkg::IDX_BITS'(1);
            state_in = ST_SH_RD;
         end
         ST_FR_RD: begin
            rd_addr  = '0;
            state_in = ST_BK_RD;
         end
         ST_BK_RD: begin
            front_in = rd_hdl_ff;
            // an empty store reads a don't-care entry here, masked below
            rd_addr  = rmml_pkg::IDX_BITS'(count_ff - rmml_pkg::CNT_BITS'(1));
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = status_ff;
            rsp_in.entry_count  = 5'(count_ff);
            rsp_in.is_empty     = (count_ff == '0);
            if (count_ff == '0) begin
               rsp_in.min_handle = '0;
               rsp_in.max_handle = '0;
            end else begin
               rsp_in.min_handle = 16'(front_ff);
               rsp_in.max_handle = 16'(rd_hdl_ff);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      op_hdl_ff  <= op_hdl_in;
      op_key_ff  <= op_key_in;
      front_ff   <= front_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   // fill count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rmml_pkg::CNT_BITS'(rmml_pkg::DEPTH))
      else $error("entry count above depth");

   // a full report only comes from a full store
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status == rmml_pkg::STATUS_FULL)
      |-> (count_ff == rmml_pkg::CNT_BITS'(rmml_pkg::DEPTH)))
      else $error("full status with free entries");

   // empty flag agrees with the count, and handles read zero then
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.is_empty == (rsp_item.entry_count == '0)) &&
                     (!rsp_item.is_empty ||
                      (rsp_item.min_handle == '0 && rsp_item.max_handle == '0))))
      else $error("empty flag or handles inconsistent");

   // the block is ready again once the result is shown
   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while result shown");

   // a refused request leaves the count as it was
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != rmml_pkg::STATUS_DONE)
      |-> $stable(count_ff))
      else $error("count changed on a failed request");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the ranked min/max list
// ----------------------------------------------------------------------------
// Items go in through the start/busy command port. The bench keeps its own
// ordered copy of the entries and predicts each result when its item is
// accepted. A checker compares every rsp_valid strobe with the oldest
// prediction. The directed tests cover empty, tie, duplicate and full-store
// behavior. The random test then sweeps the fill level up and down with
// random gaps between items.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_PERIOD = 8;
   localparam int          RESET_CYCLES = 11;
   localparam int          RANDOM_ITEMS = 1500;
   // covers about 1550 items, each at its slowest and with the longest idle gap
   localparam int          CYCLE_LIMIT  = 500_000;
   localparam int          DRAIN_CYCLES = 2 * rmml_pkg::DEPTH + 20;
   localparam logic [15:0] HANDLE_MASK  = 16'((32'd1 << rmml_pkg::HSTORE_BITS) - 1);

   // one held entry of the ordered list, front at index 0
   typedef struct {
      logic [15:0] handle;
      logic [23:0] key;
   } held_entry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   rmml_pkg::req_type req_item = '0;
   logic              rsp_valid;
   rmml_pkg::rsp_type rsp_item;

   held_entry_type    held_entries[$];     // predicted contents of the list
   rmml_pkg::rsp_type expected_results[$]; // predicted results not yet seen
   int                error_count  = 0;
   int                cycle_count  = 0;
   bit                start_raised = 1'b0; // start is (or will be) high after this step

   ranked_min_max_list DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // prediction: apply one item to the local list, return its result
   // ---------------------------------------------------------------------
   function automatic rmml_pkg::rsp_type predict_list_op(input rmml_pkg::req_type item);
      rmml_pkg::rsp_type result;
      held_entry_type    fresh;
      int                pos;
      logic [15:0]       wanted;
      wanted = item.handle & HANDLE_MASK;
      result = '0;
      pos    = 0;
      if (item.mode == rmml_pkg::MODE_INSERT) begin
         if (held_entries.size() >= rmml_pkg::DEPTH) begin
            // full store: nothing changes
            result.status = rmml_pkg::STATUS_FULL;
         end else begin
            // new entry goes ahead of every entry with an equal or larger key
            while (pos < held_entries.size() && held_entries[pos].key < item.key)
               pos++;
            fresh.handle = wanted;
            fresh.key    = item.key;
            held_entries.insert(pos, fresh);
            result.status = rmml_pkg::STATUS_DONE;
         end
      end else begin
         // only the match nearest the front goes; key is ignored
         while (pos < held_entries.size() && held_entries[pos].handle != wanted)
            pos++;
         if (pos >= held_entries.size()) begin
            result.status = rmml_pkg::STATUS_NOT_FOUND;
         end else begin
            held_entries.delete(pos);
            result.status = rmml_pkg::STATUS_DONE;
         end
      end
      result.entry_count = 5'(held_entries.size());
      if (held_entries.size() == 0) begin
         // empty store reports zero handles
         result.is_empty = 1'b1;
      end else begin
         result.min_handle = held_entries[0].handle;
         result.max_handle = held_entries[held_entries.size() - 1].handle;
      end
      return result;
   endfunction

   // ---------------------------------------------------------------------
   // result checker: each strobe is matched against the oldest prediction
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d (0x%0h), actual %0d (0x%0h)",
                name, want, want, got, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rmml_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("result with no item outstanding: status %0d count %0d",
                   rsp_item.status, rsp_item.entry_count);
            error_count++;
         end else begin
            want = expected_results[0];
            expected_results.delete(0);
            check_field("status",      want.status,      rsp_item.status);
            check_field("min_handle",  want.min_handle,  rsp_item.min_handle);
            check_field("max_handle",  want.max_handle,  rsp_item.max_handle);
            check_field("entry_count", want.entry_count, rsp_item.entry_count);
            check_field("is_empty",    want.is_empty,    rsp_item.is_empty);
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers; all are entered just after a rising edge
   // ---------------------------------------------------------------------

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // present one item, wait for it to be taken, then idle for gap cycles
   task automatic send_item(input rmml_pkg::req_type item, input int unsigned gap);
      logic [63:0] noise_bits;
      start        <= 1'b1;
      req_item     <= item;
      start_raised  = 1'b1;
      // busy is sampled as it stood at the edge, so this edge took the item
      do @(posedge clock); while (busy !== 1'b0);
      expected_results = {expected_results, predict_list_op(item)};
      if (gap > 0) begin
         start        <= 1'b0;
         start_raised  = 1'b0;
         repeat (gap) begin
            // junk on the request bus while start is low must be ignored
            noise_bits = {$urandom, $urandom};
            req_item  <= rmml_pkg::req_type'(noise_bits[$bits(rmml_pkg::req_type)-1:0]);
            @(posedge clock);
         end
      end
   endtask

   // hold off until every predicted result has come back
   task automatic wait_for_results();
      if (start_raised) begin
         start        <= 1'b0;
         start_raised  = 1'b0;
      end
      while (expected_results.size() > 0) @(posedge clock);
   endtask

   function automatic rmml_pkg::req_type make_req(input rmml_pkg::mode_type mode,
                                                  input logic [15:0] handle,
                                                  input logic [23:0] key);
      rmml_pkg::req_type item;
      item.mode   = mode;
      item.handle = handle;
      item.key    = key;
      return item;
   endfunction

   // random item; removes mostly name a held handle so they hit
   function automatic rmml_pkg::req_type random_list_req(input int unsigned insert_pct);
      rmml_pkg::req_type item;
      int unsigned       roll;
      item.key = 24'($urandom);
      if ($urandom_range(0, 99) < insert_pct) begin
         item.mode = rmml_pkg::MODE_INSERT;
         roll = $urandom_range(0, 99);
         if (roll < 30)
            item.handle = 16'($urandom_range(0, 7));     // duplicates
         else if (roll < 40 && held_entries.size() > 0)
            item.handle = held_entries[$urandom_range(0, held_entries.size() - 1)].handle;
         else
            item.handle = 16'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 40)
            item.key = 24'($urandom_range(0, 7));        // ties
         else if (roll < 50)
            item.key = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
      end else begin
         item.mode = rmml_pkg::MODE_REMOVE;
         if (held_entries.size() > 0 && $urandom_range(0, 99) < 80)
            item.handle = held_entries[$urandom_range(0, held_entries.size() - 1)].handle;
         else
            item.handle = 16'($urandom);
      end
      return item;
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // empty store, extreme handles and keys, key ignored on remove
   task automatic test_empty_and_extremes();
      send_item(make_req(rmml_pkg::MODE_REMOVE, 16'h0001, 24'h000000), 0);  // absent, empty
      send_item(make_req(rmml_pkg::MODE_INSERT, 16'h0000, 24'h000000), 0);
      send_item(make_req(rmml_pkg::MODE_INSERT, 16'hFFFF, 24'hFFFFFF), 3);
      send_item(make_req(rmml_pkg::MODE_REMOVE, 16'hFFFF, 24'h000000), 0);  // back entry
      send_item(make_req(rmml_pkg::MODE_REMOVE, 16'h0000, 24'hFFFFFF), 0);  // key ignored
      wait_for_results();
   endtask

   // equal keys put the newest first, duplicates go one at a time
   task automatic test_ties_and_duplicates();
      send_item(make_req(rmml_pkg::MODE_INSERT, 16'h00AA, 24'h000005), 0);
      send_item(make_req(rmml_pkg::MODE_INSERT, 16'h00BB, 24'h000005), 0);
      send_item(make_req(rmml_pkg::MODE_INSERT, 16'h00CC, 24'h000005), 1);
      send_item(make_req(rmml_pkg::MODE_INSERT, 16'h00AA, 24'h000009), 0);  // duplicate
      send_item(make_req(rmml_pkg::MODE_REMOVE, 16'h00AA, 24'h123456), 0);  // nearest front
      send_item(make_req(rmml_pkg::MODE_REMOVE, 16'hBEEF, 24'h000000), 2);  // absent
   endtask

   // fill to the top, refuse one more, then take from the front
   task automatic test_full_store();
      while (held_entries.size() < rmml_pkg::DEPTH)
         send_item(make_req(rmml_pkg::MODE_INSERT, 16'h5500 + 16'(held_entries.size()),
                            24'($urandom_range(0, 20))), 0);
      send_item(make_req(rmml_pkg::MODE_INSERT, 16'h7777, 24'h000000), 0);  // full
      send_item(make_req(rmml_pkg::MODE_REMOVE, held_entries[0].handle, 24'h000000), 0);
      wait_for_results();
   endtask

   // bursts that lean toward filling or draining, so the count sweeps 0..DEPTH
   task automatic test_random_traffic();
      int          sent;
      int          burst;
      int unsigned insert_pct;
      bit          no_idle;
      sent  = 0;
      burst = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 50;
            default: insert_pct = 15;
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(20, 60)) begin
            send_item(random_list_req(insert_pct), no_idle ? 0 : pick_gap());
            sent++;
         end
         burst++;
         // let the pipe run dry now and then
         if (burst % 5 == 0) wait_for_results();
      end
      wait_for_results();
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_extremes();
      test_ties_and_duplicates();
      test_full_store();
      test_random_traffic();

      // drained; give a late or extra strobe time to show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/rmml_pkg.sv
hw/rtl/ranked_min_max_list.sv
bench/testbench.sv
